// File: design/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection core.
// No dependencies; imported by ray_triangle_intersect_core and rti_decide.
package rti_pkg;

    localparam int COORD_WIDTH_DEF = 16;  // default coordinate width, signed Q.8
    localparam int EPS_W           = 16;  // width of the parallel threshold
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd17;  // about 1e-6 in Q.24
    localparam int REG_IDX_W       = 2;
    localparam int OUT_TDATA_W     = 8;   // hit padded to one byte

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VERTEX_A    = 2'd0,
        REG_VERTEX_B    = 2'd1,
        REG_VERTEX_C    = 2'd2,
        REG_DET_EPSILON = 2'd3
    } t_reg_idx;

endpackage

// File: design/ray_triangle_intersect_core.sv
// Ray/triangle intersection core (Moller-Trumbore, exact fixed point, no divide).
// Depends on rti_pkg, rti_cross, rti_dot and rti_decide.
//
// Usage:
//   Slave stream s_axis_*: one ray per transfer, six signed Q.8 coordinates.
//   Master stream m_axis_*: one result per ray, bit 0 of tdata is hit.
//   Config port i_cfg_*: index 0..2 load vertex A, B, C (x, y, z packed from
//   the low bits), index 3 loads the |det| threshold in units of 2^-24.
//   Write config only while no ray is in flight.
// Pipeline and throughput:
//   Seven register stages: input stage (edges and origin offset), cross
//   products (2), dot products (2), sign fold, compare. The transfer edge loads
//   the first one, and m_axis_tvalid rises when the ray's result reaches the
//   compare stage, from which it can transfer.
//   One ray per cycle is sustained while m_axis_tready stays high; the seven register stages advance together.
// Reset:
//   Synchronous, active low. Clears all stage valid bits and sets the vertices
//   to zero and the threshold to 17.
// Backpressure:
//   When the output holds a result that is not taken, the whole pipeline holds,
//   bubbles included, and s_axis_tready drops; all stages advance again in the
//   cycle the result transfers.
module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // ray in
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up, zero padded
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // result out
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // hit at bit 0, zero padded
    output logic [rti_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [rti_pkg::REG_IDX_W-1:0]          i_cfg_idx,
    input  logic [3*COORD_WIDTH-1:0]               i_cfg_wdata
);
    import rti_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int VTX_W  = 3 * CW;
    localparam int KEEP_W = (VTX_W > 64) ? 64 : VTX_W;
    localparam int EW     = CW + 1;        // edges and origin offset
    localparam int HW     = CW + EW + 1;   // h = dir x e2
    localparam int QW     = EW + EW + 1;   // q = s x e1
    localparam int DW     = 3 * CW + 6;    // all dot products
    localparam int LAT    = 7;

    // configuration registers
    logic [VTX_W-1:0] r_vtx_a, r_vtx_b, r_vtx_c;
    logic [EPS_W-1:0] r_eps;
    logic [VTX_W-1:0] n_vtx;

    always_comb begin
        for (int b = 0; b < VTX_W; b++) begin
            n_vtx[b] = (b < KEEP_W) ? i_cfg_wdata[b] : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a <= '0;
            r_vtx_b <= '0;
            r_vtx_c <= '0;
            r_eps   <= EPS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_VERTEX_A:    r_vtx_a <= n_vtx;
                REG_VERTEX_B:    r_vtx_b <= n_vtx;
                REG_VERTEX_C:    r_vtx_c <= n_vtx;
                REG_DET_EPSILON: r_eps   <= i_cfg_wdata[EPS_W-1:0];
            endcase
        end
    end

    // pipeline control: all stages advance together
    logic           pipe_en;
    logic [LAT-1:0] r_vld;

    assign pipe_en       = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: edges and origin offset
    logic signed [CW-1:0] va [3], vb [3], vc [3], org [3], dir [3];
    logic signed [EW-1:0] n_e1 [3], n_e2 [3], n_s [3];
    logic signed [CW-1:0] r_s1_dir [3], r_s2_dir [3], r_s3_dir [3];
    logic signed [EW-1:0] r_s1_e1 [3], r_s2_e1 [3], r_s3_e1 [3];
    logic signed [EW-1:0] r_s1_e2 [3], r_s2_e2 [3], r_s3_e2 [3];
    logic signed [EW-1:0] r_s1_s [3], r_s2_s [3], r_s3_s [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            va[k]   = r_vtx_a[k*CW +: CW];
            vb[k]   = r_vtx_b[k*CW +: CW];
            vc[k]   = r_vtx_c[k*CW +: CW];
            org[k]  = s_axis_tdata[k*CW +: CW];
            dir[k]  = s_axis_tdata[(k+3)*CW +: CW];
            n_e1[k] = EW'(vb[k]) - EW'(va[k]);
            n_e2[k] = EW'(vc[k]) - EW'(va[k]);
            n_s[k]  = EW'(org[k]) - EW'(va[k]);
        end
    end

    // hold operands alongside the cross products until the dot stage
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_dir <= dir;
            r_s1_e1  <= n_e1;
            r_s1_e2  <= n_e2;
            r_s1_s   <= n_s;
            r_s2_dir <= r_s1_dir;
            r_s2_e1  <= r_s1_e1;
            r_s2_e2  <= r_s1_e2;
            r_s2_s   <= r_s1_s;
            r_s3_dir <= r_s2_dir;
            r_s3_e1  <= r_s2_e1;
            r_s3_e2  <= r_s2_e2;
            r_s3_s   <= r_s2_s;
        end
    end

    // stages 2-3: cross products
    logic signed [HW-1:0] h_vec [3];
    logic signed [QW-1:0] q_vec [3];

    rti_cross #(.AW(CW), .BW(EW)) u_cross_h (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_s1_dir),
        .i_b   (r_s1_e2),
        .o_c   (h_vec)
    );

    rti_cross #(.AW(EW), .BW(EW)) u_cross_q (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_s1_s),
        .i_b   (r_s1_e1),
        .o_c   (q_vec)
    );

    // stages 4-5: dot products
    logic signed [DW-1:0] det, u_num, v_num, t_num;

    rti_dot #(.AW(EW), .BW(HW), .OW(DW)) u_dot_det (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_s3_e1),
        .i_b   (h_vec),
        .o_sum (det)
    );

    rti_dot #(.AW(EW), .BW(HW), .OW(DW)) u_dot_u (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_s3_s),
        .i_b   (h_vec),
        .o_sum (u_num)
    );

    rti_dot #(.AW(CW), .BW(QW), .OW(DW)) u_dot_v (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_s3_dir),
        .i_b   (q_vec),
        .o_sum (v_num)
    );

    rti_dot #(.AW(EW), .BW(QW), .OW(DW)) u_dot_t (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_a   (r_s3_e2),
        .i_b   (q_vec),
        .o_sum (t_num)
    );

    // stages 6-7: sign fold and range tests
    logic hit;

    rti_decide #(.W(DW)) u_decide (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_det (det),
        .i_un  (u_num),
        .i_vn  (v_num),
        .i_tn  (t_num),
        .i_eps (r_eps),
        .o_hit (hit)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, hit};

endmodule

// File: design/rti_cross.sv
// Two-stage pipelined cross product a x b of signed vectors.
// Stage one registers the six products, stage two the three differences.
module rti_cross #(
    parameter int AW = 16,
    parameter int BW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a [3],
    input  logic signed [BW-1:0] i_b [3],
    output logic signed [AW+BW:0] o_c [3]
);
    localparam int PW = AW + BW;

    logic signed [PW-1:0] n_prod [6];
    logic signed [PW-1:0] r_prod [6];
    logic signed [PW:0]   n_c [3];
    logic signed [PW:0]   r_c [3];

    always_comb begin
        n_prod[0] = i_a[1] * i_b[2];
        n_prod[1] = i_a[2] * i_b[1];
        n_prod[2] = i_a[2] * i_b[0];
        n_prod[3] = i_a[0] * i_b[2];
        n_prod[4] = i_a[0] * i_b[1];
        n_prod[5] = i_a[1] * i_b[0];
        n_c[0]    = (PW + 1)'(r_prod[0]) - (PW + 1)'(r_prod[1]);
        n_c[1]    = (PW + 1)'(r_prod[2]) - (PW + 1)'(r_prod[3]);
        n_c[2]    = (PW + 1)'(r_prod[4]) - (PW + 1)'(r_prod[5]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_c    <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

// File: design/rti_dot.sv
// Two-stage pipelined dot product of signed vectors.
// Stage one registers the three products, stage two their sum at width OW.
module rti_dot #(
    parameter int AW = 17,
    parameter int BW = 34,
    parameter int OW = 54
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a [3],
    input  logic signed [BW-1:0] i_b [3],
    output logic signed [OW-1:0] o_sum
);
    localparam int PW = AW + BW;

    logic signed [PW-1:0] n_prod [3];
    logic signed [PW-1:0] r_prod [3];
    logic signed [OW-1:0] n_sum;
    logic signed [OW-1:0] r_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = i_a[k] * i_b[k];
        end
        n_sum = OW'(r_prod[0]) + OW'(r_prod[1]) + OW'(r_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// File: design/rti_decide.sv
// Final two stages: fold the sign of det into the numerators, then run the
// range tests against |det| and the threshold. Depends on rti_pkg.
module rti_decide #(
    parameter int W = 54
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [W-1:0]        i_det,
    input  logic signed [W-1:0]        i_un,
    input  logic signed [W-1:0]        i_vn,
    input  logic signed [W-1:0]        i_tn,
    input  logic [rti_pkg::EPS_W-1:0]  i_eps,
    output logic                       o_hit
);
    import rti_pkg::*;

    logic signed [W:0]   n_det, n_un, n_vn, n_tn;
    logic signed [W:0]   r_det, r_un, r_vn, r_tn;
    logic signed [W:0]   eps_ext;
    logic signed [W+1:0] uv_sum;
    logic                n_hit;
    logic                r_hit;

    assign eps_ext = {{(W + 1 - EPS_W){1'b0}}, i_eps};

    always_comb begin
        // negate everything when det is negative
        if (i_det[W-1]) begin
            n_det = -((W + 1)'(i_det));
            n_un  = -((W + 1)'(i_un));
            n_vn  = -((W + 1)'(i_vn));
            n_tn  = -((W + 1)'(i_tn));
        end else begin
            n_det = (W + 1)'(i_det);
            n_un  = (W + 1)'(i_un);
            n_vn  = (W + 1)'(i_vn);
            n_tn  = (W + 1)'(i_tn);
        end
        uv_sum = (W + 2)'(r_un) + (W + 2)'(r_vn);
        n_hit  = (r_det >= eps_ext)
              && !r_un[W] && (r_un <= r_det)
              && !r_vn[W] && (uv_sum <= r_det)
              && !r_tn[W] && (r_tn != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= n_det;
            r_un  <= n_un;
            r_vn  <= n_vn;
            r_tn  <= n_tn;
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// File: sim/tb_ray_triangle_intersect_core.sv
// Testbench for ray_triangle_intersect_core: streams rays against triangles written
// through the config port and checks every hit flag against a local exact-integer predictor.
// Depends on rti_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_ray_triangle_intersect_core;
    import rti_pkg::*;

    localparam int CW      = COORD_WIDTH_DEF;
    localparam int LATENCY = 7;
    localparam int ONE     = 256;  // 1.0 in Q8.8

    typedef logic signed [127:0] t_acc;

    // origin_x sits in the low bits, dir_z in the high bits
    typedef struct packed {
        logic [CW-1:0] dir_z;
        logic [CW-1:0] dir_y;
        logic [CW-1:0] dir_x;
        logic [CW-1:0] origin_z;
        logic [CW-1:0] origin_y;
        logic [CW-1:0] origin_x;
    } t_ray;

    typedef enum int {
        SHAPE_MODERATE,
        SHAPE_TINY,
        SHAPE_EXTREME
    } t_shape;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [6*CW-1:0]              s_axis_tdata;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [OUT_TDATA_W-1:0]       m_axis_tdata;
    logic                         i_cfg_we;
    logic [REG_IDX_W-1:0]         i_cfg_idx;
    logic [3*CW-1:0]              i_cfg_wdata;

    // predictor copy of the register file
    logic [3*CW-1:0] corner_a, corner_b, corner_c;
    logic [EPS_W-1:0] det_floor;

    bit expected_hits[$];
    int mismatch_count = 0;
    bit back_to_back = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ray_triangle_intersect_core #(
        .COORD_WIDTH(CW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    function automatic t_acc widen(input logic [CW-1:0] c);
        return {{(128-CW){c[CW-1]}}, c};
    endfunction

    function automatic int coord(input logic [3*CW-1:0] v, input int k);
        logic signed [CW-1:0] c;
        c = v[k*CW +: CW];
        return int'(c);
    endfunction

    // Exact Moller-Trumbore without division: numerators folded by sign of det.
    function automatic bit predict_hit(input t_ray r);
        t_acc ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
        t_acc dx, dy, dz, sx, sy, sz, hx, hy, hz, qx, qy, qz;
        t_acc det, u_num, v_num, t_num, eps;
        ax  = widen(corner_a[0 +: CW]);
        ay  = widen(corner_a[CW +: CW]);
        az  = widen(corner_a[2*CW +: CW]);
        e1x = widen(corner_b[0 +: CW]) - ax;
        e1y = widen(corner_b[CW +: CW]) - ay;
        e1z = widen(corner_b[2*CW +: CW]) - az;
        e2x = widen(corner_c[0 +: CW]) - ax;
        e2y = widen(corner_c[CW +: CW]) - ay;
        e2z = widen(corner_c[2*CW +: CW]) - az;
        dx  = widen(r.dir_x);
        dy  = widen(r.dir_y);
        dz  = widen(r.dir_z);
        sx  = widen(r.origin_x) - ax;
        sy  = widen(r.origin_y) - ay;
        sz  = widen(r.origin_z) - az;
        hx  = dy * e2z - dz * e2y;
        hy  = dz * e2x - dx * e2z;
        hz  = dx * e2y - dy * e2x;
        det = e1x * hx + e1y * hy + e1z * hz;
        qx  = sy * e1z - sz * e1y;
        qy  = sz * e1x - sx * e1z;
        qz  = sx * e1y - sy * e1x;
        u_num = sx * hx + sy * hy + sz * hz;
        v_num = dx * qx + dy * qy + dz * qz;
        t_num = e2x * qx + e2y * qy + e2z * qz;
        if (det < 0) begin
            det   = -det;
            u_num = -u_num;
            v_num = -v_num;
            t_num = -t_num;
        end
        eps = {{(128-EPS_W){1'b0}}, det_floor};
        return (det >= eps) && (u_num >= 0) && (u_num <= det) && (v_num >= 0)
            && (u_num + v_num <= det) && (t_num > 0);
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 3))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return rand_span(32768);
        endcase
    endfunction

    function automatic logic [3*CW-1:0] pack_vertex(input int x, input int y, input int z);
        return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    function automatic t_ray make_ray(input int ox, input int oy, input int oz,
                                      input int dx, input int dy, input int dz);
        t_ray r;
        r.origin_x = ox[CW-1:0];
        r.origin_y = oy[CW-1:0];
        r.origin_z = oz[CW-1:0];
        r.dir_x    = dx[CW-1:0];
        r.dir_y    = dy[CW-1:0];
        r.dir_z    = dz[CW-1:0];
        return r;
    endfunction

    function automatic t_ray noise_ray();
        return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Aim at a point near the triangle; the weights never go below zero but their
    // sum runs a little past one, so both sides of the edge from B to C get hit.
    function automatic t_ray aimed_ray(input int reach);
        int w1, w2, a, off;
        int o[3], d[3];
        w1 = $urandom_range(0, 288);
        w2 = $urandom_range(0, 300 - w1);
        for (int k = 0; k < 3; k++) begin
            a    = coord(corner_a, k);
            off  = rand_span(reach);
            o[k] = a + (w1 * (coord(corner_b, k) - a) + w2 * (coord(corner_c, k) - a)) / ONE
                   + off;
            d[k] = -off;
        end
        // point away from the triangle now and then
        if ($urandom_range(0, 7) == 0) begin
            for (int k = 0; k < 3; k++)
                d[k] = -d[k];
        end
        return make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endfunction

    // Direction along an edge: determinant is zero.
    function automatic t_ray parallel_ray(input int reach);
        int which;
        int o[3], d[3];
        which = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            case (which)
                0: d[k] = coord(corner_b, k) - coord(corner_a, k);
                1: d[k] = coord(corner_c, k) - coord(corner_a, k);
                default: d[k] = coord(corner_c, k) - coord(corner_b, k);
            endcase
            o[k] = coord(corner_a, k) + rand_span(reach);
        end
        return make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endfunction

    task automatic send_ray(input t_ray ray);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ray;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_hits.push_back(predict_hit(ray));
    endtask

    // Drop valid, let every result drain, then give the pipeline time to empty.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [3*CW-1:0] val);
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_VERTEX_A:    corner_a  = val;
            REG_VERTEX_B:    corner_b  = val;
            REG_VERTEX_C:    corner_c  = val;
            REG_DET_EPSILON: det_floor = val[EPS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_triangle(input logic [3*CW-1:0] a, input logic [3*CW-1:0] b,
                                input logic [3*CW-1:0] c, input logic [EPS_W-1:0] eps);
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        // junk in the upper bits must be ignored
        write_reg(REG_DET_EPSILON, {$urandom, eps});
    endtask

    task automatic random_triangle(input t_shape shape);
        int c[9];
        logic [EPS_W-1:0] eps;
        for (int k = 0; k < 9; k++) begin
            case (shape)
                SHAPE_MODERATE: c[k] = rand_span(8000);
                SHAPE_TINY:     c[k] = rand_span(6);
                default:        c[k] = extreme_coord();
            endcase
        end
        case ($urandom_range(0, 3))
            0: eps = '0;
            1: eps = EPS_RESET;
            2: eps = '1;
            default: eps = EPS_W'($urandom);
        endcase
        if (shape == SHAPE_TINY && $urandom_range(0, 3) != 0)
            eps = EPS_W'($urandom_range(0, 64));
        set_triangle(pack_vertex(c[0], c[1], c[2]), pack_vertex(c[3], c[4], c[5]),
                     pack_vertex(c[6], c[7], c[8]), eps);
    endtask

    task automatic run_rays(input t_shape shape, input int n_rays);
        int reach, pick;
        reach = (shape == SHAPE_TINY) ? 8 : 8000;
        for (int i = 0; i < n_rays; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                send_ray(aimed_ray(reach));
            else if (pick < 17)
                send_ray(parallel_ray(reach));
            else
                send_ray(noise_ray());
        end
    endtask

    // Registers at reset: degenerate triangle at the origin, threshold 17.
    task automatic test_reset_values();
        send_ray(make_ray(64, 64, ONE, 0, 0, -ONE));
        send_ray(noise_ray());
        send_ray(noise_ray());
    endtask

    task automatic test_unit_triangle();
        wait_idle();
        set_triangle(pack_vertex(0, 0, 0), pack_vertex(ONE, 0, 0), pack_vertex(0, ONE, 0),
                     EPS_RESET);
        send_ray(make_ray(64, 64, ONE, 0, 0, -ONE));       // inside
        send_ray(make_ray(ONE, ONE, ONE, 0, 0, -ONE));     // outside
        send_ray(make_ray(0, 0, ONE, 0, 0, -ONE));         // on vertex A, u = v = 0
        send_ray(make_ray(128, 128, ONE, 0, 0, -ONE));     // on edge, u + v = 1
        send_ray(make_ray(64, 64, ONE, 0, 0, ONE));        // pointing away, t < 0
        send_ray(make_ray(64, 64, 0, 0, 0, -ONE));         // origin in plane, t = 0
        send_ray(make_ray(64, 64, ONE, ONE, 0, 0));        // parallel
        send_ray(make_ray(64, 64, -ONE, 0, 0, ONE));       // from below, det < 0
    endtask

    task automatic test_field_extremes();
        send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767));
        send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768));
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        send_ray(make_ray(32767, -32768, 32767, -32768, 32767, -32768));
    endtask

    // Zero threshold with zero determinant: only the comparisons decide.
    task automatic test_zero_epsilon();
        wait_idle();
        write_reg(REG_DET_EPSILON, '0);
        send_ray(make_ray(64, 64, 0, ONE, 0, 0));
        send_ray(make_ray(64, 64, ONE, 0, ONE, 0));
        wait_idle();
        set_triangle(pack_vertex(ONE, ONE, ONE), pack_vertex(ONE, ONE, ONE),
                     pack_vertex(ONE, ONE, ONE), '0);
        send_ray(make_ray(0, 0, 0, ONE, ONE, ONE));
        send_ray(make_ray(ONE, ONE, ONE, 0, 0, 0));
    endtask

    task automatic test_extreme_vertices();
        wait_idle();
        set_triangle(pack_vertex(-32768, -32768, -32768), pack_vertex(32767, 32767, -32768),
                     pack_vertex(-32768, 32767, 32767), '1);
        send_ray(make_ray(0, 0, 0, 32767, -32768, 32767));
        send_ray(make_ray(-32768, 32767, -32768, 1, 1, 1));
        send_ray(noise_ray());
    endtask

    task automatic test_random_triangles();
        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            random_triangle(t_shape'(ph % 3));
            back_to_back = ($urandom_range(0, 3) == 0);
            run_rays(t_shape'(ph % 3), 60);
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_back_to_back();
        wait_idle();
        random_triangle(SHAPE_MODERATE);
        back_to_back = 1'b1;
        run_rays(SHAPE_MODERATE, 130);
        back_to_back = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < 1000 && expected_hits.size() != 0; i++) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_hits.size() != 0) begin
            $display("%0t: missing results, expected %0d more, actual 0",
                     $time, expected_hits.size());
            mismatch_count += expected_hits.size();
        end
    endtask

    // Result sink: random stall before each transfer, none while back_to_back is set.
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = back_to_back ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_hits
        logic [OUT_TDATA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = {{(OUT_TDATA_W-1){1'b0}}, expected_hits.pop_front()};
                if (m_axis_tdata !== want) begin
                    $display("%0t: hit mismatch, expected %0h, actual %0h",
                             $time, want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        corner_a      = '0;
        corner_b      = '0;
        corner_c      = '0;
        det_floor     = EPS_RESET;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_VERTEX_A;
        i_cfg_wdata   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_unit_triangle();
        test_field_extremes();
        test_zero_epsilon();
        test_extreme_vertices();
        test_random_triangles();
        test_back_to_back();
        drain();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
